// ===== sv/ldrf_pkg.sv =====
// shared constants for the longest distinct run finder
`default_nettype none

package ldrf_pkg;

   localparam int MAX_LEN     = 256;
   // a run without repeats can never be longer than the byte alphabet
   localparam int CELL_COUNT  = (MAX_LEN < 256) ? MAX_LEN : 256;
   localparam int CHAR_W      = 8;
   localparam int CELL_IDX_W  = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
   localparam int POS_W       = $clog2(MAX_LEN + 1);
   localparam int LEN_W       = 9;
   localparam int START_W     = 8;
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = 24;

   typedef logic [CHAR_W-1:0] char_type;
   typedef logic [LEN_W-1:0]  len_type;
   typedef logic [POS_W-1:0]  pos_type;

endpackage

`default_nettype wire

// ===== sv/ldrf_cell.sv =====
// one cell of the history line: holds a past byte and compares it with the new one
`default_nettype none

module ldrf_cell (
   input  wire                     clock,
   input  wire                     shift_en,
   input  wire ldrf_pkg::char_type char_in,
   output ldrf_pkg::char_type      char_out,
   input  wire ldrf_pkg::char_type probe_code,
   input  wire                     in_window,
   output logic                    hit
);

   ldrf_pkg::char_type stored_ff;
   ldrf_pkg::char_type stored_in;

   assign stored_in = shift_en ? char_in : stored_ff;

   always_ff @(posedge clock) begin
      stored_ff <= stored_in;
   end

   assign char_out = stored_ff;
   assign hit      = in_window && (stored_ff == probe_code);

endmodule

`default_nettype wire

// ===== sv/longest_distinct_run_finder_unit.sv =====
// top level: cell chain of recent bytes plus run length and best-run tracking
//
// Usage: bytes of a string arrive on the req_ stream, one per beat, req_tlast on
// the final byte. Each byte is shifted into a row of cells that holds the most
// recent bytes; all cells inside the current window compare against the new
// byte in the same cycle, and a hit shortens the window to just past the
// earlier copy. The longest window and its start are tracked as bytes arrive.
// On the final byte one result beat is loaded into the rsp_ output register
// and all tracking state is cleared. Throughput is one byte per cycle, set by
// the combinational compare across the cell row, unless a final byte is held
// by a stall on rsp_tready behind the output register: while a
// result waits, further bytes are still taken until another final byte
// arrives, which waits in req_ until the result is taken.
// Bytes beyond the maximum length are dropped and set the overflow bit.
// Reset (synchronous, active high) clears the counters and the output valid;
// the cell contents need no reset, as the window length masks them.
`default_nettype none

module longest_distinct_run_finder_unit (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // [7:0] char_code
   input  wire         req_tlast,   // last_char
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [23:0] rsp_tdata    // [8:0] longest_length, [16:9] start_index,
                                    // [17] overflow, [23:18] zero
);

   localparam int N = ldrf_pkg::CELL_COUNT;

   ldrf_pkg::char_type chain [N];
   logic [N-1:0]       hit;
   logic [N-1:0]       in_win;

   ldrf_pkg::len_type  cur_len_ff, cur_len_in;
   ldrf_pkg::pos_type  position_ff, position_in;
   ldrf_pkg::len_type  best_len_ff, best_len_in;
   logic [7:0]         best_start_ff, best_start_in;
   logic               overflow_ff, overflow_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [23:0]        rsp_data_ff, rsp_data_in;

   logic                              accept;
   logic                              room;
   logic                              hit_any;
   logic [ldrf_pkg::CELL_IDX_W-1:0]   hit_idx;
   ldrf_pkg::len_type                 new_len;
   logic [7:0]                        new_start;
   ldrf_pkg::len_type                 run_best_len;
   logic [7:0]                        run_best_start;
   logic                              run_overflow;

   assign req_tready = !(req_tlast && rsp_valid_ff && !rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign room       = position_ff < ldrf_pkg::pos_type'(ldrf_pkg::MAX_LEN);

   // cell k holds the byte seen k+1 beats ago
   for (genvar k = 0; k < N; k++) begin : g_cell
      assign in_win[k] = ldrf_pkg::len_type'(k) < cur_len_ff;
      ldrf_cell u_cell (
         .clock      (clock),
         .shift_en   (accept && room),
         .char_in    ((k == 0) ? req_tdata : chain[(k == 0) ? 0 : k-1]),
         .char_out   (chain[k]),
         .probe_code (req_tdata),
         .in_window  (in_win[k]),
         .hit        (hit[k])
      );
   end

   // bytes in the window are distinct, so at most one cell hits
   always_comb begin
      hit_idx = '0;
      for (int k = 0; k < N; k++) begin
         if (hit[k]) begin
            hit_idx = hit_idx | ldrf_pkg::CELL_IDX_W'(k);
         end
      end
   end

   assign hit_any   = |hit;
   assign new_len   = hit_any ? ldrf_pkg::len_type'(hit_idx) + ldrf_pkg::len_type'(1)
                              : cur_len_ff + ldrf_pkg::len_type'(1);
   assign new_start = 8'(position_ff) + 8'd1 - new_len[7:0];

   always_comb begin
      run_best_len   = best_len_ff;
      run_best_start = best_start_ff;
      run_overflow   = overflow_ff;
      if (room) begin
         if (new_len > best_len_ff) begin
            run_best_len   = new_len;
            run_best_start = new_start;
         end
      end else begin
         run_overflow = 1'b1;
      end
   end

   always_comb begin
      cur_len_in    = cur_len_ff;
      position_in   = position_ff;
      best_len_in   = best_len_ff;
      best_start_in = best_start_ff;
      overflow_in   = overflow_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      if (accept) begin
         if (req_tlast) begin
            cur_len_in    = '0;
            position_in   = '0;
            best_len_in   = '0;
            best_start_in = '0;
            overflow_in   = 1'b0;
            rsp_valid_in  = 1'b1;
            rsp_data_in   = {6'd0, run_overflow, run_best_start, run_best_len};
         end else begin
            best_len_in   = run_best_len;
            best_start_in = run_best_start;
            overflow_in   = run_overflow;
            if (room) begin
               cur_len_in  = new_len;
               position_in = position_ff + ldrf_pkg::pos_type'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_len_ff    <= '0;
         position_ff   <= '0;
         best_len_ff   <= '0;
         best_start_ff <= '0;
         overflow_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cur_len_ff    <= cur_len_in;
         position_ff   <= position_in;
         best_len_ff   <= best_len_in;
         best_start_ff <= best_start_in;
         overflow_ff   <= overflow_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== sim/longest_distinct_run_finder_unit_tb.sv =====
// self-checking testbench for the longest distinct run finder, directed strings then random ones
module longest_distinct_run_finder_unit_tb;

   typedef struct packed {
      logic       overflow;
      logic [7:0] start;
      logic [8:0] length;
   } run_result_t;

   typedef struct packed {
      logic [7:0]  code;
      logic        last;
      logic        typed;
      run_result_t result;
   } dir_row_t;

   localparam int DIR_ROWS   = 19;
   localparam int RAND_BYTES = 1500;

   // typed results only where they are plain: one-byte strings, a full repeat, two distinct bytes
   dir_row_t directed_rows [DIR_ROWS] = '{
      '{8'h00, 1'b1, 1'b1, '{1'b0, 8'd0, 9'd1}},
      '{8'hFF, 1'b1, 1'b1, '{1'b0, 8'd0, 9'd1}},
      '{8'h41, 1'b0, 1'b0, '0},
      '{8'h41, 1'b1, 1'b1, '{1'b0, 8'd0, 9'd1}},
      // earlier copy of the last byte sits before the window
      '{8'h61, 1'b0, 1'b0, '0},
      '{8'h62, 1'b0, 1'b0, '0},
      '{8'h62, 1'b0, 1'b0, '0},
      '{8'h61, 1'b1, 1'b0, '0},
      // equal runs, earlier one kept
      '{8'h61, 1'b0, 1'b0, '0},
      '{8'h62, 1'b0, 1'b0, '0},
      '{8'h61, 1'b0, 1'b0, '0},
      '{8'h62, 1'b1, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h80, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h7F, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b1, 1'b0, '0},
      '{8'h55, 1'b0, 1'b0, '0},
      '{8'hAA, 1'b1, 1'b1, '{1'b0, 8'd0, 9'd2}}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;    // [7:0] char_code
   logic        req_tlast = 1'b0;  // last_char
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // [8:0] longest_length, [16:9] start_index, [17] overflow

   // string tracker state
   int run_origin;
   int byte_count;
   int best_len;
   int best_origin;
   int last_seen_at [256];
   bit seen_in_string [256];
   bit dropped_bytes;

   run_result_t expected_runs [$];
   int  mismatch_count = 0;
   int  bytes_sent = 0;
   bit  sender_calm = 1'b0;
   bit  receiver_calm = 1'b0;

   longest_distinct_run_finder_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #1 clock = ~clock;

   function automatic void clear_tracker();
      run_origin = 0;
      byte_count = 0;
      best_len = 0;
      best_origin = 0;
      dropped_bytes = 1'b0;
      for (int i = 0; i < 256; i++) begin
         last_seen_at[i] = 0;
         seen_in_string[i] = 1'b0;
      end
   endfunction

   // advance the window by one byte; returns 1 with the run result on the final byte
   function automatic bit track_byte(input logic [7:0] code, input bit last,
                                     output run_result_t res);
      int run_len;
      res = '0;
      if (byte_count < ldrf_pkg::MAX_LEN) begin
         if (seen_in_string[code] && last_seen_at[code] >= run_origin)
            run_origin = last_seen_at[code] + 1;
         last_seen_at[code] = byte_count;
         seen_in_string[code] = 1'b1;
         run_len = byte_count - run_origin + 1;
         if (run_len > best_len) begin
            best_len = run_len;
            best_origin = run_origin;
         end
         byte_count++;
      end else begin
         dropped_bytes = 1'b1;
      end
      if (!last)
         return 1'b0;
      res.length = best_len[8:0];
      res.start = best_origin[7:0];
      res.overflow = dropped_bytes;
      clear_tracker();
      return 1'b1;
   endfunction

   function automatic void note_mismatch(string what, int expv, int actv);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch %s: expected %0d, got %0d", what, expv, actv);
   endfunction

   task automatic send_byte(input logic [7:0] code, input logic last, input logic typed,
                            input run_result_t typed_res);
      int          gap;
      run_result_t res;
      gap = sender_calm ? 0 : $urandom_range(0, 10);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= code;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
      if (track_byte(code, last, res))
         expected_runs.push_back(typed ? typed_res : res);
   endtask

   initial begin
      logic [7:0] str [$];
      logic [7:0] perm [256];
      logic [7:0] pattern [8];
      logic [7:0] swap;
      int         string_index;
      int         len;
      int         alpha;
      int         period;
      int         base;
      int         j;
      clear_tracker();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < DIR_ROWS; r++)
         send_byte(directed_rows[r].code, directed_rows[r].last, directed_rows[r].typed,
                   directed_rows[r].result);

      bytes_sent = 0;
      string_index = 0;
      while (bytes_sent < RAND_BYTES) begin
         string_index++;
         if ($urandom_range(0, 7) == 0)
            sender_calm = !sender_calm;
         str.delete();
         if (string_index % 40 == 13) begin
            // every byte value once, sometimes followed by bytes past the length limit
            for (int i = 0; i < 256; i++)
               perm[i] = i[7:0];
            for (int i = 255; i > 0; i--) begin
               j = $urandom_range(0, i);
               swap = perm[i];
               perm[i] = perm[j];
               perm[j] = swap;
            end
            for (int i = 0; i < 256; i++)
               str.push_back(perm[i]);
            len = $urandom_range(0, 4);
            for (int i = 0; i < len; i++)
               str.push_back(8'($urandom_range(0, 255)));
         end else if (string_index % 40 == 33) begin
            len = $urandom_range(200, 300);
            for (int i = 0; i < len; i++)
               str.push_back(8'($urandom_range(0, 255)));
         end else begin
            case ($urandom_range(0, 3))
               0, 1: begin
                  // narrow alphabet so repeats are frequent
                  len = $urandom_range(1, 12);
                  alpha = $urandom_range(1, 8);
                  base = $urandom_range(0, 255);
                  for (int i = 0; i < len; i++)
                     str.push_back(8'(base + $urandom_range(0, alpha - 1)));
               end
               2: begin
                  len = $urandom_range(1, 40);
                  for (int i = 0; i < len; i++)
                     str.push_back(8'($urandom_range(0, 255)));
               end
               default: begin
                  // repeating pattern gives many equal-length runs
                  len = $urandom_range(1, 30);
                  period = $urandom_range(1, 8);
                  for (int i = 0; i < 8; i++)
                     pattern[i] = 8'($urandom_range(0, 255));
                  for (int i = 0; i < len; i++)
                     str.push_back(pattern[i % period]);
               end
            endcase
         end
         for (int i = 0; i < str.size(); i++)
            send_byte(str[i], i == str.size() - 1, 1'b0, '0);
      end
      req_tvalid <= 1'b0;

      while (expected_runs.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("PASS longest_distinct_run_finder_unit");
      else
         $display("FAIL longest_distinct_run_finder_unit");
      $finish;
   end

   initial begin
      int stall;
      while (reset)
         @(posedge clock);
      forever begin
         stall = receiver_calm ? 0 : $urandom_range(0, 10);
         if ($urandom_range(0, 7) == 0)
            receiver_calm = !receiver_calm;
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   always @(posedge clock) begin
      run_result_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_runs.size() == 0) begin
            note_mismatch("result beat with none expected", -1, rsp_tdata);
         end else begin
            want = expected_runs.pop_front();
            if (rsp_tdata[8:0] !== want.length)
               note_mismatch("longest_length", want.length, rsp_tdata[8:0]);
            if (rsp_tdata[16:9] !== want.start)
               note_mismatch("start_index", want.start, rsp_tdata[16:9]);
            if (rsp_tdata[17] !== want.overflow)
               note_mismatch("overflow", want.overflow, rsp_tdata[17]);
         end
      end
   end

   initial begin
      #1000000;
      $display("FAIL longest_distinct_run_finder_unit");
      $finish;
   end

endmodule
